@@ rtl/rvx_pkg.sv @@
package rvx_pkg;

  localparam int REG_COUNT     = 32;
  localparam int REG_IDX_BITS  = $clog2(REG_COUNT);
  localparam int CSR_ADDR_BITS = 12;
  localparam int CSR_DEPTH     = 1 << CSR_ADDR_BITS;
  localparam int FIFO_DEPTH    = 2;

  localparam logic [6:0]  OP_ADDI    = 7'h13;
  localparam logic [6:0]  OP_RTYPE   = 7'h33;
  localparam logic [6:0]  OP_BEQ     = 7'h63;
  localparam logic [6:0]  OP_JAL     = 7'h6F;
  localparam logic [6:0]  OP_JALR    = 7'h67;
  localparam logic [6:0]  OP_LUI     = 7'h37;
  localparam logic [6:0]  OP_AUIPC   = 7'h17;
  localparam logic [6:0]  OP_SYSTEM  = 7'h73;
  localparam logic [6:0]  FUNCT7_ALT = 7'h20;
  localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

  typedef enum logic [3:0] {
    K_BAD, K_ADDI, K_ADD, K_SUB, K_SLL, K_SRL, K_SRA, K_OR, K_AND,
    K_BEQ, K_JAL, K_JALR, K_LUI, K_AUIPC, K_CSR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    logic [31:0] imm;
    logic [CSR_ADDR_BITS-1:0] csr_sel;
  } uop_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic        branch_taken;
    logic        unsupported;
  } res_t;

endpackage

@@ rtl/rvx_ram.sv @@
module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/rvx_decode.sv @@
module rvx_decode (
  input  logic              [31:0] word,
  output rvx_pkg::uop_t            uop
);
  import rvx_pkg::*;

  logic [6:0] op;
  logic [2:0] f3;
  logic [6:0] f7;

  always_comb begin
    op = word[6:0];
    f3 = word[14:12];
    f7 = word[31:25];
    uop.rd = word[11:7];
    uop.rs1 = word[19:15];
    uop.rs2 = word[24:20];
    uop.f3 = f3;
    uop.csr_sel = word[20 +: CSR_ADDR_BITS];
    uop.imm = {{20{word[31]}}, word[31:20]};
    uop.kind = K_BAD;
    case (op)
      OP_ADDI: if (f3 == 3'd0) uop.kind = K_ADDI;
      OP_RTYPE: begin
        if (f3 == 3'd0 && f7 == 7'd0) uop.kind = K_ADD;
        else if (f3 == 3'd0 && f7 == FUNCT7_ALT) uop.kind = K_SUB;
        else if (f3 == 3'd1 && f7 == 7'd0) uop.kind = K_SLL;
        else if (f3 == 3'd5 && f7 == 7'd0) uop.kind = K_SRL;
        else if (f3 == 3'd5 && f7 == FUNCT7_ALT) uop.kind = K_SRA;
        else if (f3 == 3'd6 && f7 == 7'd0) uop.kind = K_OR;
        else if (f3 == 3'd7 && f7 == 7'd0) uop.kind = K_AND;
      end
      OP_BEQ: begin
        uop.imm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
        if (f3 == 3'd0) uop.kind = K_BEQ;
      end
      OP_JAL: begin
        uop.imm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
        uop.kind = K_JAL;
      end
      OP_JALR: if (f3 == 3'd0) uop.kind = K_JALR;
      OP_LUI: begin
        uop.imm = word & UPPER_MASK;
        uop.kind = K_LUI;
      end
      OP_AUIPC: begin
        uop.imm = word & UPPER_MASK;
        uop.kind = K_AUIPC;
      end
      OP_SYSTEM: if (f3[1:0] != 2'd0) uop.kind = K_CSR;
      default: uop.kind = K_BAD;
    endcase
  end
endmodule

@@ rtl/rvx_front.sv @@
// Decode stage plus a small queue; ready depends only on queue fill.
module rvx_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic          [31:0] in_tdata,
  output logic                 q_valid,
  input  logic                 q_take,
  output rvx_pkg::uop_t        q_uop
);
  import rvx_pkg::*;

  uop_t       dec;
  uop_t       buf_r [FIFO_DEPTH];
  logic       rp_r, rp_nxt, wp_r, wp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  rvx_decode u_dec (.word(in_tdata), .uop(dec));

  assign in_tready = (cnt_r != 2'(FIFO_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_uop     = buf_r[rp_r];

  always_comb begin
    rp_nxt  = rp_r ^ (q_take && q_valid);
    wp_nxt  = wp_r ^ push;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_take && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= 1'b0;
      wp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wp_r] <= dec;
    end
  end
endmodule

@@ rtl/rvx_back.sv @@
// Execute: one uop per cycle when not stalled. Old CSR value is a registered
// RAM read issued in the previous cycle; bypass covers a same-address write.
module rvx_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic          [31:0] start_address,
  input  logic                 q_valid,
  output logic                 q_take,
  input  rvx_pkg::uop_t        q_uop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output rvx_pkg::res_t        res
);
  import rvx_pkg::*;

  logic [31:0] gpr_r [REG_COUNT];
  logic [31:0] pc_r;
  logic        started_r;
  res_t        res_r;
  logic        ov_r;
  // CSR clear sweep
  logic        clr_r;
  logic [CSR_ADDR_BITS:0] clr_cnt_r;
  // staged uop whose CSR read is in flight
  logic        st_v_r;
  uop_t        st_r;
  logic        byp_v_r;
  logic [31:0] byp_r;

  logic [31:0] csr_rd, old_v, a, b, pc, val, nxt, csr_nv;
  logic        wr, tk, bad, csr_we, exec, load_st;
  logic [CSR_ADDR_BITS-1:0] ram_wa, ram_ra;
  logic [31:0] ram_wd;
  logic [4:0]  sh;

  rvx_ram #(.WIDTH(32), .DEPTH(CSR_DEPTH)) u_csr (
    .clk(clk), .we(csr_we || clr_r), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(csr_rd));

  function automatic logic [31:0] rd_reg(input logic [4:0] i,
                                        input logic [31:0] r [REG_COUNT]);
    if (i == 5'd0 || 32'(i) >= REG_COUNT) return 32'd0;
    return r[i[REG_IDX_BITS-1:0]];
  endfunction

  assign exec    = st_v_r && (!ov_r || out_tready) && !clr_r;
  assign load_st = !clr_r && (!st_v_r || exec);
  assign q_take  = load_st;
  // a stalled uop keeps re-reading its own entry
  assign ram_ra  = load_st ? q_uop.csr_sel : st_r.csr_sel;

  always_comb begin
    old_v = byp_v_r ? byp_r : csr_rd;
    a  = rd_reg(st_r.rs1, gpr_r);
    b  = rd_reg(st_r.rs2, gpr_r);
    pc = started_r ? pc_r : start_address;
    sh = b[4:0];
    val = 32'd0; nxt = pc + 32'd4; wr = 1'b1; tk = 1'b0; bad = 1'b0;
    csr_nv = old_v; csr_we = 1'b0;
    case (st_r.kind)
      K_ADDI:  val = a + st_r.imm;
      K_ADD:   val = a + b;
      K_SUB:   val = a - b;
      K_SLL:   val = a << sh;
      K_SRL:   val = a >> sh;
      K_SRA:   val = $unsigned($signed(a) >>> sh);
      K_OR:    val = a | b;
      K_AND:   val = a & b;
      K_BEQ: begin
        wr = 1'b0;
        if (a == b) begin nxt = pc + st_r.imm; tk = 1'b1; end
      end
      K_JAL:   begin val = pc + 32'd4; nxt = pc + st_r.imm; tk = 1'b1; end
      K_JALR:  begin val = pc + 32'd4; nxt = (a + st_r.imm) & ~32'd1; tk = 1'b1; end
      K_LUI:   val = st_r.imm;
      K_AUIPC: val = pc + st_r.imm;
      K_CSR: begin
        logic [31:0] src;
        src = st_r.f3[2] ? {27'd0, st_r.rs1} : a;
        case (st_r.f3[1:0])
          2'd1:    csr_nv = src;
          2'd2:    csr_nv = old_v | src;
          default: csr_nv = old_v & ~src;
        endcase
        val = old_v;
        csr_we = exec;
      end
      default: begin wr = 1'b0; bad = 1'b1; nxt = pc; end
    endcase
    if (!wr || st_r.rd == 5'd0) val = 32'd0;
    ram_wa = clr_r ? clr_cnt_r[CSR_ADDR_BITS-1:0] : st_r.csr_sel;
    ram_wd = clr_r ? 32'd0 : csr_nv;
  end

  assign out_tvalid = ov_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      ov_r <= 1'b0;
      st_v_r <= 1'b0;
      byp_v_r <= 1'b0;
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
      for (int i = 0; i < REG_COUNT; i++) gpr_r[i] <= 32'd0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (CSR_ADDR_BITS+1)'(CSR_DEPTH - 1)) clr_r <= 1'b0;
      end
      if (exec) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      if (load_st) st_v_r <= q_valid;
      else if (exec) st_v_r <= 1'b0;
      if (load_st) begin
        byp_v_r <= exec && csr_we && q_uop.csr_sel == st_r.csr_sel;
      end
      if (exec && !bad) begin
        pc_r <= nxt;
        started_r <= 1'b1;
        if (wr && st_r.rd != 5'd0 && 32'(st_r.rd) < REG_COUNT)
          gpr_r[st_r.rd[REG_IDX_BITS-1:0]] <= val;
      end
    end
    if (load_st) begin
      st_r <= q_uop;
      byp_r <= csr_nv;
    end
    if (exec) begin
      res_r.next_pc <= nxt;
      res_r.dest_index <= st_r.rd;
      res_r.dest_value <= val;
      res_r.dest_written <= wr && st_r.rd != 5'd0 && 32'(st_r.rd) < REG_COUNT;
      res_r.branch_taken <= tk;
      res_r.unsupported <= bad;
    end
  end
endmodule

@@ rtl/rv32i_subset_executor_unit.sv @@
// Channel | Ports         | Payload (low bit up)
// in      | in_t*         | tdata: instruction_word[31:0]
// out     | out_t*        | tdata: next_pc, dest_index, dest_value (72 bits, zero pad)
//         |               | tuser: dest_written, branch_taken, unsupported
// cfg     | cfg_we/wdata  | start_address
// One item per cycle sustained while the output is not stalled; after the accepting
// edge an item passes queue entry, staged uop with CSR read, execute/output register.
// The CSR RAM read port sets the extra stage.
// After reset a clearing pass zeroes all 4096 entries of the CSR store; items queue
// (up to two) but do not execute during it.
// Output stalls back up through the stage and queue into in_tready.
module rv32i_subset_executor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // instruction_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // next_pc, dest_index, dest_value, zeros
  output logic [2:0]  out_tuser,  // dest_written, branch_taken, unsupported
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import rvx_pkg::*;

  logic        q_valid, q_take;
  uop_t        q_uop;
  res_t        res;

  logic [31:0] start_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) start_addr_r <= 32'd0;
    else if (cfg_we) start_addr_r <= cfg_wdata;
  end

  rvx_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .q_valid(q_valid), .q_take(q_take), .q_uop(q_uop));

  rvx_back u_back (
    .clk(clk), .rst_n(rst_n), .start_address(start_addr_r),
    .q_valid(q_valid), .q_take(q_take), .q_uop(q_uop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .res(res));

  assign out_tdata = {3'd0, res.dest_value, res.dest_index, res.next_pc};
  assign out_tuser = {res.unsupported, res.branch_taken, res.dest_written};

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[0] && !out_tuser[1])
    else $error("unsupported item with side effects");
  a_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[36:32] == 5'd0 |-> out_tdata[68:37] == 32'd0 && !out_tuser[0])
    else $error("x0 written");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while waiting");
endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import rvx_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  rv32i_subset_executor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // shadow architectural state
  logic [31:0] gpr [REG_COUNT];
  logic [31:0] csr_mem [CSR_DEPTH];
  logic [31:0] pc_q, start_addr;
  logic        pc_live;

  res_t retire_q [$];
  int   errors = 0;
  int   send_idle_pct = 0, recv_idle_pct = 0;
  bit   recv_hold = 1'b0;
  int   quiet_cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
    errors++;
  endtask

  function automatic logic [31:0] rd_gpr(input logic [4:0] i);
    return (i == 0 || i >= REG_COUNT) ? 32'h0 : gpr[i];
  endfunction

  function automatic res_t execute_word(input logic [31:0] w);
    res_t r;
    logic [31:0] pc, a, b, val, nxt, imm_i, imm_b, imm_j, old, nv, src;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [CSR_ADDR_BITS-1:0] ca;
    logic        wr, tk, bad;
    pc = pc_live ? pc_q : start_addr;
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    a = rd_gpr(w[19:15]); b = rd_gpr(w[24:20]);
    nxt = pc + 32'd4; val = '0; wr = 1'b0; tk = 1'b0; bad = 1'b0;
    case (op)
      OP_ADDI: if (f3 == 0) begin val = a + imm_i; wr = 1'b1; end else bad = 1'b1;
      OP_RTYPE: begin
        wr = 1'b1;
        if (f3 == 0 && f7 == 0) val = a + b;
        else if (f3 == 0 && f7 == FUNCT7_ALT) val = a - b;
        else if (f3 == 1 && f7 == 0) val = a << b[4:0];
        else if (f3 == 5 && f7 == 0) val = a >> b[4:0];
        else if (f3 == 5 && f7 == FUNCT7_ALT) val = $signed(a) >>> b[4:0];
        else if (f3 == 6 && f7 == 0) val = a | b;
        else if (f3 == 7 && f7 == 0) val = a & b;
        else begin wr = 1'b0; bad = 1'b1; end
      end
      OP_BEQ: if (f3 == 0) begin
        if (a == b) begin nxt = pc + imm_b; tk = 1'b1; end
      end else bad = 1'b1;
      OP_JAL: begin val = pc + 32'd4; wr = 1'b1; nxt = pc + imm_j; tk = 1'b1; end
      OP_JALR: if (f3 == 0) begin
        val = pc + 32'd4; wr = 1'b1; nxt = (a + imm_i) & ~32'd1; tk = 1'b1;
      end else bad = 1'b1;
      OP_LUI: begin val = w & UPPER_MASK; wr = 1'b1; end
      OP_AUIPC: begin val = pc + (w & UPPER_MASK); wr = 1'b1; end
      OP_SYSTEM: begin
        ca = w[20 +: CSR_ADDR_BITS];
        src = f3[2] ? {27'h0, w[19:15]} : a;
        old = csr_mem[ca];
        nv = old;
        case (f3[1:0])
          2'd1: nv = src;
          2'd2: nv = old | src;
          2'd3: nv = old & ~src;
          default: bad = 1'b1;
        endcase
        if (!bad) begin csr_mem[ca] = nv; val = old; wr = 1'b1; end
      end
      default: bad = 1'b1;
    endcase
    r = '0;
    r.dest_index = rd;
    if (bad) begin
      nxt = pc; val = '0; tk = 1'b0;
    end else begin
      if (wr && rd != 0) begin
        if (rd < REG_COUNT) begin gpr[rd] = val; r.dest_written = 1'b1; end
      end else val = '0;
      pc_q = nxt; pc_live = 1'b1;
    end
    r.next_pc = nxt; r.dest_value = val; r.branch_taken = tk; r.unsupported = bad;
    return r;
  endfunction

  // sender: returns at the edge that accepted the item, valid still high
  task automatic offer(input logic [31:0] w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_word(input logic [31:0] w);
    offer(w);
    retire_q.push_back(execute_word(w));
  endtask

  task automatic write_start(input logic [31:0] v);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_addr = v;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (retire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver and checker
  always @(posedge clk) begin
    res_t exp;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        quiet_cycles <= 0;
        if (retire_q.size() == 0) begin
          $display("unexpected item at %0t", $time);
          errors++;
        end else begin
          exp = retire_q.pop_front();
          if (out_tdata[31:0] !== exp.next_pc) report("next_pc", out_tdata[31:0], exp.next_pc);
          if (out_tdata[36:32] !== exp.dest_index)
            report("dest_index", 32'(out_tdata[36:32]), 32'(exp.dest_index));
          if (out_tdata[68:37] !== exp.dest_value)
            report("dest_value", out_tdata[68:37], exp.dest_value);
          if (out_tuser[0] !== exp.dest_written)
            report("dest_written", 32'(out_tuser[0]), 32'(exp.dest_written));
          if (out_tuser[1] !== exp.branch_taken)
            report("branch_taken", 32'(out_tuser[1]), 32'(exp.branch_taken));
          if (out_tuser[2] !== exp.unsupported)
            report("unsupported", 32'(out_tuser[2]), 32'(exp.unsupported));
        end
      end else if (in_tvalid && in_tready) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_tready <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // long receiver hold-off so the pipe backs up into in_tready
  task automatic hold_receiver(input int cycles);
    recv_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold = 1'b0;
  endtask

  // instruction encoders
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
      input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
      input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [4:0] rs2,
      input logic [4:0] rs1);
    return {off[12], off[10:5], rs2, rs1, 3'd0, off[4:1], off[11], OP_BEQ};
  endfunction

  function automatic logic [31:0] rand_word();
    logic [4:0] rd, r1, r2;
    int sel;
    rd = 5'($urandom_range(31)); r1 = 5'($urandom_range(31)); r2 = 5'($urandom_range(31));
    // mostly few registers so values chain through reads
    if ($urandom_range(3) != 0) begin
      rd = 5'($urandom_range(7)); r1 = 5'($urandom_range(7)); r2 = 5'($urandom_range(7));
    end
    sel = $urandom_range(19);
    case (sel)
      0, 1: return enc_i(12'($urandom), r1, 3'd0, rd, OP_ADDI);
      2: return enc_r(7'h0, r2, r1, 3'd0, rd, OP_RTYPE);
      3: return enc_r(FUNCT7_ALT, r2, r1, 3'd0, rd, OP_RTYPE);
      4: return enc_r(7'h0, r2, r1, 3'd1, rd, OP_RTYPE);
      5: return enc_r(7'h0, r2, r1, 3'd5, rd, OP_RTYPE);
      6: return enc_r(FUNCT7_ALT, r2, r1, 3'd5, rd, OP_RTYPE);
      7: return enc_r(7'h0, r2, r1, 3'd6, rd, OP_RTYPE);
      8: return enc_r(7'h0, r2, r1, 3'd7, rd, OP_RTYPE);
      9: return enc_b(13'($urandom), r2, r1);
      10: return {20'($urandom), rd, OP_JAL};
      11: return enc_i(12'($urandom), r1, 3'd0, rd, OP_JALR);
      12: return {20'($urandom), rd, OP_LUI};
      13: return {20'($urandom), rd, OP_AUIPC};
      14, 15: return enc_i($urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(7)),
                           r1, 3'($urandom_range(7)), rd, OP_SYSTEM);
      16: return enc_i(12'($urandom), r1, 3'($urandom_range(1, 7)), rd,
                        $urandom_range(1) ? OP_ADDI : OP_JALR);
      17: return enc_r(7'($urandom), r2, r1, 3'($urandom), rd, OP_RTYPE);
      default: return $urandom;
    endcase
  endfunction

  typedef struct {
    logic [31:0] word;
    bit          typed;
    logic [31:0] next_pc;
    logic [31:0] value;
    logic        unsup;
  } stim_row_t;

  stim_row_t dir_rows [$];

  initial begin
    stim_row_t row;
    res_t got_exp;
    for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
    for (int i = 0; i < CSR_DEPTH; i++) csr_mem[i] = '0;
    start_addr = '0; pc_q = '0; pc_live = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_start(32'hFFFF_FFF0);

    // directed rows: typed ones are obvious from reset state
    dir_rows = '{
      '{32'hFFFF_FFFF, 1, 32'hFFFF_FFF0, 32'h0, 1},
      '{32'h0000_0000, 1, 32'hFFFF_FFF0, 32'h0, 1},
      '{enc_i(12'hFFF, 5'd0, 3'd0, 5'd1, OP_ADDI), 1, 32'hFFFF_FFF4, 32'hFFFF_FFFF, 0},
      '{enc_i(12'h7FF, 5'd0, 3'd0, 5'd2, OP_ADDI), 1, 32'hFFFF_FFF8, 32'h0000_07FF, 0},
      '{enc_r(7'h0, 5'd2, 5'd1, 3'd0, 5'd3, OP_RTYPE), 0, 0, 0, 0},
      '{enc_r(FUNCT7_ALT, 5'd1, 5'd2, 3'd0, 5'd4, OP_RTYPE), 0, 0, 0, 0},
      '{enc_r(7'h0, 5'd2, 5'd1, 3'd1, 5'd5, OP_RTYPE), 0, 0, 0, 0},
      '{enc_r(7'h0, 5'd2, 5'd1, 3'd5, 5'd6, OP_RTYPE), 0, 0, 0, 0},
      '{enc_r(FUNCT7_ALT, 5'd2, 5'd1, 3'd5, 5'd7, OP_RTYPE), 0, 0, 0, 0},
      '{enc_r(7'h0, 5'd2, 5'd1, 3'd6, 5'd8, OP_RTYPE), 0, 0, 0, 0},
      '{enc_r(7'h0, 5'd2, 5'd1, 3'd7, 5'd0, OP_RTYPE), 0, 0, 0, 0},
      '{enc_r(7'h1, 5'd2, 5'd1, 3'd2, 5'd9, OP_RTYPE), 0, 0, 0, 1},
      '{enc_b(13'h1FFC, 5'd0, 5'd0), 0, 0, 0, 0},
      '{enc_b(13'h0FFE, 5'd1, 5'd2), 0, 0, 0, 0},
      '{{20'hFFFFF, 5'd10, OP_JAL}, 0, 0, 0, 0},
      '{enc_i(12'h801, 5'd1, 3'd0, 5'd11, OP_JALR), 0, 0, 0, 0},
      '{enc_i(12'h0, 5'd1, 3'd1, 5'd11, OP_JALR), 0, 0, 0, 1},
      '{{20'hFFFFF, 5'd12, OP_LUI}, 0, 0, 0, 0},
      '{{20'h80000, 5'd13, OP_AUIPC}, 0, 0, 0, 0},
      '{enc_i(12'hFFF, 5'd1, 3'd1, 5'd14, OP_SYSTEM), 0, 0, 0, 0},
      '{enc_i(12'hFFF, 5'd31, 3'd6, 5'd15, OP_SYSTEM), 0, 0, 0, 0},
      '{enc_i(12'hFFF, 5'd2, 3'd3, 5'd0, OP_SYSTEM), 0, 0, 0, 0},
      '{enc_i(12'hFFF, 5'd0, 3'd2, 5'd16, OP_SYSTEM), 0, 0, 0, 0},
      '{enc_i(12'hFFF, 5'd31, 3'd7, 5'd17, OP_SYSTEM), 0, 0, 0, 0},
      '{enc_i(12'hFFF, 5'd1, 3'd4, 5'd18, OP_SYSTEM), 0, 0, 0, 1}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.typed) begin
        got_exp = execute_word(row.word);
        if (got_exp.next_pc !== row.next_pc || got_exp.dest_value !== row.value ||
            got_exp.unsupported !== row.unsup) begin
          $display("directed row %0d disagrees with table", i);
          errors++;
        end
        // shadow state already advanced, so queue the checked result directly
        offer(row.word);
        retire_q.push_back(got_exp);
      end else send_word(row.word);
    end
    wait_drained();

    // random phases across start addresses; pc keeps running from the directed rows, so
    // no setting here hits an unstarted pc, each just exercises the write
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 34; recv_idle_pct = 60; write_start(32'h0); end
        1: begin send_idle_pct = 60; recv_idle_pct = 34; write_start(32'hFFFF_FFFF); end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; write_start($urandom); end
      endcase
      if (ph == 2) begin
        fork
          hold_receiver(300);
          for (int n = 0; n < 40; n++) send_word(rand_word());
        join
      end
      for (int n = 0; n < 360; n++) send_word(rand_word());
      wait_drained();
    end

    if (retire_q.size() == 0 && errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
